>>> src/smme_pkg.sv
// types, constants and control program for the source map mappings encoder
`default_nettype none

package smme_pkg;

    typedef struct packed {
        logic signed [31:0] gen_line;
        logic signed [31:0] gen_col;
        logic signed [31:0] src_idx;
        logic signed [31:0] src_line;
        logic signed [31:0] src_col;
        logic signed [31:0] name_idx;
    } t_in;

    typedef struct packed {
        logic [7:0]  out_char;
        logic [30:0] repeat_count;
        logic        error;
        logic        last;
    } t_out;

    localparam logic [7:0] CHAR_SEMI  = 8'h3B;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_NONE  = 8'h00;

    // micro-operations
    typedef enum logic [2:0] {
        OP_CHECK,
        OP_LINE,
        OP_COMMA,
        OP_LOAD,
        OP_DIGIT,
        OP_COMMIT
    } t_op;

    typedef enum logic [2:0] {
        FLD_GC,
        FLD_SI,
        FLD_SL,
        FLD_SC,
        FLD_NI
    } t_fld;

    // when a digit step marks its final digit as the item's last beat
    typedef enum logic [1:0] {
        LAST_NEVER,
        LAST_IF_NO_NAME,
        LAST_ALWAYS
    } t_last;

    typedef enum logic {
        COND_NONE,
        COND_NO_NAME
    } t_cond;

    localparam int unsigned STEP_W = 4;

    localparam logic [STEP_W-1:0] STEP_CHECK    = 4'd0;
    localparam logic [STEP_W-1:0] STEP_LINE     = 4'd1;
    localparam logic [STEP_W-1:0] STEP_COMMA    = 4'd2;
    localparam logic [STEP_W-1:0] STEP_LOAD_GC  = 4'd3;
    localparam logic [STEP_W-1:0] STEP_DIG_GC   = 4'd4;
    localparam logic [STEP_W-1:0] STEP_LOAD_SI  = 4'd5;
    localparam logic [STEP_W-1:0] STEP_DIG_SI   = 4'd6;
    localparam logic [STEP_W-1:0] STEP_LOAD_SL  = 4'd7;
    localparam logic [STEP_W-1:0] STEP_DIG_SL   = 4'd8;
    localparam logic [STEP_W-1:0] STEP_LOAD_SC  = 4'd9;
    localparam logic [STEP_W-1:0] STEP_DIG_SC   = 4'd10;
    localparam logic [STEP_W-1:0] STEP_LOAD_NI  = 4'd11;
    localparam logic [STEP_W-1:0] STEP_DIG_NI   = 4'd12;
    localparam logic [STEP_W-1:0] STEP_COMMIT   = 4'd13;

    typedef struct packed {
        t_op               op;
        t_fld              fld;
        t_last             last_mode;
        t_cond             cond;
        logic [STEP_W-1:0] target;
    } t_ctl;

    // control store
    function automatic t_ctl prog_rom(input logic [STEP_W-1:0] step);
        t_ctl c;
        c = '{op: OP_COMMIT, fld: FLD_GC, last_mode: LAST_NEVER,
              cond: COND_NONE, target: STEP_CHECK};
        case (step)
            STEP_CHECK:   c.op = OP_CHECK;
            STEP_LINE:    c.op = OP_LINE;
            STEP_COMMA:   c.op = OP_COMMA;
            STEP_LOAD_GC: begin c.op = OP_LOAD;  c.fld = FLD_GC; end
            STEP_DIG_GC:  c.op = OP_DIGIT;
            STEP_LOAD_SI: begin c.op = OP_LOAD;  c.fld = FLD_SI; end
            STEP_DIG_SI:  c.op = OP_DIGIT;
            STEP_LOAD_SL: begin c.op = OP_LOAD;  c.fld = FLD_SL; end
            STEP_DIG_SL:  c.op = OP_DIGIT;
            STEP_LOAD_SC: begin c.op = OP_LOAD;  c.fld = FLD_SC; end
            STEP_DIG_SC:  begin c.op = OP_DIGIT; c.last_mode = LAST_IF_NO_NAME; end
            STEP_LOAD_NI: begin
                c.op     = OP_LOAD;
                c.fld    = FLD_NI;
                c.cond   = COND_NO_NAME;
                c.target = STEP_COMMIT;
            end
            STEP_DIG_NI:  begin c.op = OP_DIGIT; c.last_mode = LAST_ALWAYS; end
            STEP_COMMIT:  c.op = OP_COMMIT;
            default:      c.op = OP_COMMIT;
        endcase
        return c;
    endfunction

    // base64 digit alphabet
    function automatic logic [7:0] b64_char(input logic [5:0] d);
        logic [7:0] ch;
        if (d < 6'd26) begin
            ch = 8'h41 + {2'b00, d};
        end else if (d < 6'd52) begin
            ch = 8'h61 + {2'b00, d} - 8'd26;
        end else if (d < 6'd62) begin
            ch = 8'h30 + {2'b00, d} - 8'd52;
        end else if (d == 6'd62) begin
            ch = 8'h2B;
        end else begin
            ch = 8'h2F;
        end
        return ch;
    endfunction

endpackage

`default_nettype wire

>>> src/source_map_mapping_encoder.sv
// top level: source map v3 mappings encoder driven by a small control store
`default_nettype none

// Encodes one mapping per input beat into source map v3 mappings text, one
// character per output beat. A line advance gives one ';' beat whose
// repeat_count is the line gap, a ',' separates segments on one line, then
// come the base64 VLQ digits of the generated column, source index, source
// line, source column and (when a name index other than -1 is given) name
// index, each as a delta against the previous mapping. A bad mapping, or any
// mapping after a failure, gives a single error beat and the encoder stays
// failed until reset.
// Items are taken one at a time: a microcoded sequencer steps through a
// fourteen-entry control store, one step per cycle unless an output stall
// holds it, and the next item is accepted in the cycle after the last step
// has run. An item is taken in, then runs the check, the line step, the
// comma step, a load for each of the five delta slots (the name slot's load
// also runs when there is no name and then jumps to commit), one digit step
// per VLQ digit, with at most seven digits per delta, and the commit step.
// A rejected item ends at the check step. The digit steps, the error beat of
// the check step and the ';' and ',' beats wait while the output register
// holds a beat that the consumer has not taken.

module source_map_mapping_encoder (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    output logic              o_ready,
    input  smme_pkg::t_in     i_data,
    output logic              o_valid,
    input  wire               i_ready,
    output smme_pkg::t_out    o_data
);

    // sequencer state
    logic                            r_busy, n_busy;
    logic [smme_pkg::STEP_W-1:0]     r_step, n_step;
    smme_pkg::t_in                   r_in, n_in;
    logic [31:0]                     r_vlq, n_vlq;

    // encoder state
    logic [30:0] r_line, n_line;
    logic [30:0] r_pgc, n_pgc;
    logic [30:0] r_psi, n_psi;
    logic [30:0] r_psl, n_psl;
    logic [30:0] r_psc, n_psc;
    logic [30:0] r_pni, n_pni;
    logic        r_seg, n_seg;
    logic        r_healthy, n_healthy;

    // output register
    logic            r_ov, n_ov;
    smme_pkg::t_out  r_out, n_out;

    smme_pkg::t_ctl  ctl;
    logic            slot_free;
    logic            bad_in, line_back, col_back, err;
    logic            no_name, line_adv;
    logic [30:0]     gap;
    logic [30:0]     sel_x, sel_p;
    logic [31:0]     d_fwd, d_rev;
    logic            d_neg;
    logic [30:0]     d_mag;
    logic            more;
    logic            dig_last;

    assign o_ready = !r_busy;
    assign o_valid = r_ov;
    assign o_data  = r_out;

    always_comb begin
        ctl       = smme_pkg::prog_rom(r_step);
        slot_free = !r_ov || i_ready;

        // validity checks; a set sign bit fails before the compares matter
        bad_in    = r_in.gen_line[31] || r_in.gen_col[31] ||
                    r_in.src_idx[31] || r_in.src_line[31] ||
                    r_in.src_col[31] ||
                    (r_in.name_idx[31] && (r_in.name_idx != -32'sd1));
        line_back = r_in.gen_line[30:0] < r_line;
        col_back  = (r_in.gen_line[30:0] == r_line) &&
                    (r_in.gen_col[30:0] < r_pgc);
        err       = !r_healthy || bad_in || line_back || col_back;

        // once checked, a negative name index can only be "no name"
        no_name   = r_in.name_idx[31];
        line_adv  = r_in.gen_line[30:0] != r_line;
        gap       = r_in.gen_line[30:0] - r_line;

        // operand select for the delta unit
        case (ctl.fld)
            smme_pkg::FLD_GC: begin sel_x = r_in.gen_col[30:0];  sel_p = r_pgc; end
            smme_pkg::FLD_SI: begin sel_x = r_in.src_idx[30:0];  sel_p = r_psi; end
            smme_pkg::FLD_SL: begin sel_x = r_in.src_line[30:0]; sel_p = r_psl; end
            smme_pkg::FLD_SC: begin sel_x = r_in.src_col[30:0];  sel_p = r_psc; end
            smme_pkg::FLD_NI: begin sel_x = r_in.name_idx[30:0]; sel_p = r_pni; end
            default:          begin sel_x = r_in.gen_col[30:0];  sel_p = r_pgc; end
        endcase
        d_fwd = {1'b0, sel_x} - {1'b0, sel_p};
        d_rev = {1'b0, sel_p} - {1'b0, sel_x};
        d_neg = d_fwd[31];
        d_mag = d_neg ? d_rev[30:0] : d_fwd[30:0];

        // digit unit: low five bits out, continuation when more remain
        more = |r_vlq[31:5];
        case (ctl.last_mode)
            smme_pkg::LAST_NEVER:      dig_last = 1'b0;
            smme_pkg::LAST_IF_NO_NAME: dig_last = !more && no_name;
            smme_pkg::LAST_ALWAYS:     dig_last = !more;
            default:                   dig_last = 1'b0;
        endcase

        n_busy    = r_busy;
        n_step    = r_step;
        n_in      = r_in;
        n_vlq     = r_vlq;
        n_line    = r_line;
        n_pgc     = r_pgc;
        n_psi     = r_psi;
        n_psl     = r_psl;
        n_psc     = r_psc;
        n_pni     = r_pni;
        n_seg     = r_seg;
        n_healthy = r_healthy;
        n_ov      = r_ov && !i_ready;
        n_out     = r_out;

        if (!r_busy) begin
            if (i_valid) begin
                n_in   = i_data;
                n_busy = 1'b1;
                n_step = smme_pkg::STEP_CHECK;
            end
        end else begin
            case (ctl.op)
                smme_pkg::OP_CHECK: begin
                    if (!err) begin
                        n_step = r_step + 1'b1;
                    end else if (slot_free) begin
                        // rejected item: single error beat, sticky failure
                        n_ov      = 1'b1;
                        n_out     = '{out_char: smme_pkg::CHAR_NONE, repeat_count: '0,
                                      error: 1'b1, last: 1'b1};
                        n_healthy = 1'b0;
                        n_busy    = 1'b0;
                    end
                end
                smme_pkg::OP_LINE: begin
                    if (!line_adv) begin
                        n_step = r_step + 1'b1;
                    end else if (slot_free) begin
                        n_ov   = 1'b1;
                        n_out  = '{out_char: smme_pkg::CHAR_SEMI, repeat_count: gap,
                                   error: 1'b0, last: 1'b0};
                        n_line = r_in.gen_line[30:0];
                        n_pgc  = '0;
                        n_seg  = 1'b0;
                        n_step = r_step + 1'b1;
                    end
                end
                smme_pkg::OP_COMMA: begin
                    if (!r_seg) begin
                        n_step = r_step + 1'b1;
                    end else if (slot_free) begin
                        n_ov   = 1'b1;
                        n_out  = '{out_char: smme_pkg::CHAR_COMMA, repeat_count: 31'd1,
                                   error: 1'b0, last: 1'b0};
                        n_step = r_step + 1'b1;
                    end
                end
                smme_pkg::OP_LOAD: begin
                    n_vlq = {d_mag, d_neg};
                    if (ctl.cond == smme_pkg::COND_NO_NAME && no_name) begin
                        n_step = ctl.target;
                    end else begin
                        n_step = r_step + 1'b1;
                    end
                end
                smme_pkg::OP_DIGIT: begin
                    if (slot_free) begin
                        n_ov    = 1'b1;
                        n_out   = '{out_char: smme_pkg::b64_char({more, r_vlq[4:0]}),
                                    repeat_count: 31'd1, error: 1'b0, last: dig_last};
                        n_vlq   = {5'd0, r_vlq[31:5]};
                        if (!more) begin
                            n_step = r_step + 1'b1;
                        end
                    end
                end
                smme_pkg::OP_COMMIT: begin
                    n_pgc  = r_in.gen_col[30:0];
                    n_psi  = r_in.src_idx[30:0];
                    n_psl  = r_in.src_line[30:0];
                    n_psc  = r_in.src_col[30:0];
                    if (!no_name) begin
                        n_pni = r_in.name_idx[30:0];
                    end
                    n_seg  = 1'b1;
                    n_busy = 1'b0;
                end
                default: begin
                    n_busy = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_in  <= n_in;
        r_vlq <= n_vlq;
        r_out <= n_out;
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_step    <= smme_pkg::STEP_CHECK;
            r_line    <= '0;
            r_pgc     <= '0;
            r_psi     <= '0;
            r_psl     <= '0;
            r_psc     <= '0;
            r_pni     <= '0;
            r_seg     <= 1'b0;
            r_healthy <= 1'b1;
            r_ov      <= 1'b0;
        end else begin
            r_busy    <= n_busy;
            r_step    <= n_step;
            r_line    <= n_line;
            r_pgc     <= n_pgc;
            r_psi     <= n_psi;
            r_psl     <= n_psl;
            r_psc     <= n_psc;
            r_pni     <= n_pni;
            r_seg     <= n_seg;
            r_healthy <= n_healthy;
            r_ov      <= n_ov;
        end
    end

endmodule

`default_nettype wire
